// ===== hdl/c2dc_pkg.sv =====
// Shared types and constants of the causal 2-D convolution block.
// Holds the configuration record, register index codes and fixed widths.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package c2dc_pkg;

    // pixel and coefficient formats
    localparam int PIX_W    = 8;
    localparam int PIX_MAX  = 255;
    localparam int COEF_W   = 8;
    localparam int NUM_COEF = 25;
    // one tap product: unsigned pixel times signed coefficient
    localparam int PROD_W   = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // decoupling queue and back-end depth
    localparam int QUEUE_DEPTH = 4;
    localparam int BACK_STAGES = 5;
    localparam int MAX_PENDING = QUEUE_DEPTH + BACK_STAGES;

    typedef logic [PIX_W-1:0]         t_pixel;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_ROWS  = 3'd0,
        REG_KERNEL_COLS  = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_COEFF_A      = 3'd4,
        REG_COEFF_B      = 3'd5,
        REG_COEFF_C      = 3'd6,
        REG_COEFF_D      = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [2:0]                        kernel_rows;
        logic [2:0]                        kernel_cols;
        logic [11:0]                       image_width;
        logic [15:0]                       image_height;
        logic [NUM_COEF-1:0][COEF_W-1:0]   coeff;
    } t_cfg;

    // register values after reset
    localparam logic [2:0]  KERNEL_ROWS_RST  = 3'd3;
    localparam logic [2:0]  KERNEL_COLS_RST  = 3'd3;
    localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd2048;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd1024;
    localparam logic [COEF_W-1:0] COEFF_0_RST = 8'd1;

endpackage

`default_nettype wire

// ===== hdl/c2dc_if.sv =====
// Stream interfaces of the convolution block: pixel input and result output.
// Each carries valid, ready and its payload; a word moves when both are high.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface c2dc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c2dc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/c2dc_front.sv =====
// Front end: accepts input pixels, tracks raster position and tags each word.
// Produces queue entries with column, line slot, edge masks and frame end.
// Depends on c2dc_pkg and c2dc_if.
`timescale 1ns / 1ps
`default_nettype none

module c2dc_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TAPS  = 5,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int NBANK    = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1,
    localparam int SW       = (NBANK > 1) ? $clog2(NBANK) : 1,
    localparam int ENTRY_W  = 8 + CW + SW + 2 * MAX_TAPS + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c2dc_pkg::t_cfg     i_cfg,
    c2dc_in_if.sink            i_pix,
    input  logic               i_full,
    output logic               o_push,
    output logic [ENTRY_W-1:0] o_entry
);
    import c2dc_pkg::*;

    localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NBANK - 1);

    typedef struct packed {
        t_pixel              pixel;
        logic [CW-1:0]       col;
        logic [SW-1:0]       slot;
        logic [MAX_TAPS-1:0] row_ge;
        logic [MAX_TAPS-1:0] col_ge;
        logic                frame_end;
    } t_entry;

    logic [CW-1:0] r_col, n_col;
    logic [15:0]   r_row, n_row;
    logic [SW-1:0] r_slot, n_slot;
    logic [WW-1:0] w_wid;
    logic [WW-1:0] w_col_p1;
    logic [15:0]   w_hei;
    logic [16:0]   w_row_p1;
    logic          w_last_col;
    logic          w_last_row;
    logic          w_accept;
    t_entry        w_entry;

    // take a word whenever the queue has room
    assign i_pix.ready = !i_full;
    assign w_accept    = i_pix.valid && !i_full;
    assign o_push      = w_accept;
    assign o_entry     = w_entry;

    // clamp frame size to the supported range
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_wid = WW'(1);
        end else if (WW'(i_cfg.image_width) > WW'(MAX_WIDTH)) begin
            w_wid = WW'(MAX_WIDTH);
        end else begin
            w_wid = WW'(i_cfg.image_width);
        end
        w_hei = (i_cfg.image_height == '0) ? 16'd1 : i_cfg.image_height;
    end

    // detect end of line and end of frame
    assign w_col_p1   = WW'(r_col) + WW'(1);
    assign w_row_p1   = {1'b0, r_row} + 17'd1;
    assign w_last_col = (w_col_p1 >= w_wid);
    assign w_last_row = (w_row_p1 >= {1'b0, w_hei});

    // tag the word with its position and edge masks
    always_comb begin
        w_entry.pixel     = i_pix.pixel_in;
        w_entry.col       = r_col;
        w_entry.slot      = r_slot;
        w_entry.frame_end = w_last_col && w_last_row;
        for (int k = 0; k < MAX_TAPS; k++) begin
            w_entry.row_ge[k] = (r_row >= 16'(k));
            w_entry.col_ge[k] = (r_col >= CW'(k));
        end
    end

    // advance column, row and line slot
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                if (w_last_row) begin
                    n_row  = '0;
                    n_slot = '0;
                end else begin
                    n_row  = w_row_p1[15:0];
                    n_slot = (r_slot >= LAST_SLOT) ? '0 : r_slot + SW'(1);
                end
            end else begin
                n_col = w_col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/c2dc_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Generic width; depth from the instantiating module.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module c2dc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_count, n_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // advance pointers and fill level
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (AW+1)'(1);
            2'b01:   n_count = r_count - (AW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // hold entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/c2dc_back.sv =====
// Back end: line memories, tap window, multiply, add tree, clamp, output stage.
// Five stages share one advance enable driven by the output register.
// Depends on c2dc_pkg and c2dc_if.
`timescale 1ns / 1ps
`default_nettype none

module c2dc_back #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TAPS  = 5,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int NBANK    = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1,
    localparam int SW       = (NBANK > 1) ? $clog2(NBANK) : 1,
    localparam int ENTRY_W  = 8 + CW + SW + 2 * MAX_TAPS + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c2dc_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  logic [ENTRY_W-1:0] i_q_entry,
    output logic               o_q_pop,
    c2dc_out_if.source         o_pix
);
    import c2dc_pkg::*;

    localparam int RSW = PROD_W + $clog2(MAX_TAPS);
    localparam int TW  = RSW + $clog2(MAX_TAPS);

    typedef struct packed {
        t_pixel              pixel;
        logic [CW-1:0]       col;
        logic [SW-1:0]       slot;
        logic [MAX_TAPS-1:0] row_ge;
        logic [MAX_TAPS-1:0] col_ge;
        logic                frame_end;
    } t_entry;

    typedef struct packed {
        logic [MAX_TAPS-1:0] row_ge;
        logic [MAX_TAPS-1:0] col_ge;
        logic                frame_end;
    } t_meta;

    logic   w_en;
    logic   w_pop;
    t_entry w_q;

    // stage 1: line memory read
    logic   r_v1;
    t_entry r_e1;
    t_pixel r_rd [NBANK];

    // stage 2: tap window
    logic   r_v2;
    t_meta  r_m2;
    t_pixel r_win [MAX_TAPS][MAX_TAPS];
    t_pixel w_newcol [MAX_TAPS];

    // coefficient table following the configuration
    logic [2:0] w_rows;
    logic [2:0] w_cols;
    t_coef      w_coef [MAX_TAPS][MAX_TAPS];
    t_coef      r_coef [MAX_TAPS][MAX_TAPS];

    // stage 3: products
    logic                     r_v3;
    logic                     r_fe3;
    logic signed [PROD_W-1:0] r_prod [MAX_TAPS][MAX_TAPS];

    // stage 4: row sums
    logic                  r_v4;
    logic                  r_fe4;
    logic signed [RSW-1:0] w_rsum [MAX_TAPS];
    logic signed [RSW-1:0] r_rsum [MAX_TAPS];

    // stage 5: total, clamp, output register
    logic signed [TW-1:0] w_total;
    t_pixel               w_clamp;
    logic                 r_out_valid;
    t_pixel               r_out_pixel;
    logic                 r_out_fe;

    assign w_q     = t_entry'(i_q_entry);
    assign w_en    = !r_out_valid || o_pix.ready;
    assign w_pop   = w_en && i_q_valid;
    assign o_q_pop = w_pop;

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_out = r_out_pixel;
    assign o_pix.frame_end = r_out_fe;

    // line memories: read the column of every stored row, write the new pixel
    // into the slot of the current row (the old value is read first)
    for (genvar b = 0; b < NBANK; b++) begin : g_line
        t_pixel r_line [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (w_pop) begin
                r_rd[b] <= r_line[w_q.col];
                if (w_q.slot == SW'(b)) begin
                    r_line[w_q.col] <= w_q.pixel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_e1 <= w_q;
        end
    end

    // select the stored row that lies m rows above; zero above the image
    assign w_newcol[0] = r_e1.pixel;
    for (genvar m = 1; m < MAX_TAPS; m++) begin : g_col
        logic [SW:0] w_sext;
        logic [SW:0] w_idx;
        t_pixel      w_val;

        assign w_sext = {1'b0, r_e1.slot};
        assign w_idx  = (w_sext >= (SW+1)'(m)) ? w_sext - (SW+1)'(m)
                                               : w_sext + (SW+1)'(NBANK - m);

        always_comb begin
            w_val = '0;
            if (r_e1.row_ge[m]) begin
                for (int b = 0; b < NBANK; b++) begin
                    if (w_idx == (SW+1)'(b)) begin
                        w_val = r_rd[b];
                    end
                end
            end
        end

        assign w_newcol[m] = w_val;
    end

    // shift the window one column and load the new one
    always_ff @(posedge i_clk) begin
        if (w_en && r_v1) begin
            for (int m = 0; m < MAX_TAPS; m++) begin
                r_win[m][0] <= w_newcol[m];
                for (int n = 1; n < MAX_TAPS; n++) begin
                    r_win[m][n] <= r_win[m][n-1];
                end
            end
            r_m2 <= '{row_ge: r_e1.row_ge, col_ge: r_e1.col_ge,
                      frame_end: r_e1.frame_end};
        end
    end

    // clamp kernel size and pick the coefficient of each tap
    always_comb begin
        if (i_cfg.kernel_rows == '0) begin
            w_rows = 3'd1;
        end else if (i_cfg.kernel_rows > 3'(MAX_TAPS)) begin
            w_rows = 3'(MAX_TAPS);
        end else begin
            w_rows = i_cfg.kernel_rows;
        end
        if (i_cfg.kernel_cols == '0) begin
            w_cols = 3'd1;
        end else if (i_cfg.kernel_cols > 3'(MAX_TAPS)) begin
            w_cols = 3'(MAX_TAPS);
        end else begin
            w_cols = i_cfg.kernel_cols;
        end
        for (int m = 0; m < MAX_TAPS; m++) begin
            for (int n = 0; n < MAX_TAPS; n++) begin
                w_coef[m][n] = '0;
                for (int c = 1; c <= MAX_TAPS; c++) begin
                    if (w_cols == 3'(c) && n < c && (m * c + n) < NUM_COEF
                        && 3'(m) < w_rows) begin
                        w_coef[m][n] = t_coef'(i_cfg.coeff[m * c + n]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= w_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // multiply every tap; drop taps above or left of the image
    always_ff @(posedge i_clk) begin
        if (w_en && r_v2) begin
            for (int m = 0; m < MAX_TAPS; m++) begin
                for (int n = 0; n < MAX_TAPS; n++) begin
                    if (r_m2.row_ge[m] && r_m2.col_ge[n]) begin
                        r_prod[m][n] <= $signed({{(PROD_W-PIX_W){1'b0}}, r_win[m][n]})
                                      * PROD_W'(r_coef[m][n]);
                    end else begin
                        r_prod[m][n] <= '0;
                    end
                end
            end
            r_fe3 <= r_m2.frame_end;
        end
    end

    // add each kernel row
    always_comb begin
        for (int m = 0; m < MAX_TAPS; m++) begin
            w_rsum[m] = '0;
            for (int n = 0; n < MAX_TAPS; n++) begin
                w_rsum[m] = w_rsum[m] + RSW'(r_prod[m][n]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v3) begin
            r_rsum <= w_rsum;
            r_fe4  <= r_fe3;
        end
    end

    // add the rows and clamp to the pixel range
    always_comb begin
        w_total = '0;
        for (int m = 0; m < MAX_TAPS; m++) begin
            w_total = w_total + TW'(r_rsum[m]);
        end
        if (w_total[TW-1]) begin
            w_clamp = '0;
        end else if (w_total > TW'(PIX_MAX)) begin
            w_clamp = t_pixel'(PIX_MAX);
        end else begin
            w_clamp = w_total[PIX_W-1:0];
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v4) begin
            r_out_pixel <= w_clamp;
            r_out_fe    <= r_fe4;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/causal_2d_convolution_clamp.sv =====
// Causal 2-D convolution with clamping over a raster pixel stream.
//
// Usage:
//   i_pix  : input words, one 8-bit grayscale pixel each, in raster order.
//   o_pix  : one result word per input word: the clamped sum of the kernel
//            taps at and above/left of the same position, plus frame_end on
//            the last pixel of a frame.
//   i_cfg_we/i_cfg_index/i_cfg_data : register writes (kernel size, frame
//            size, coefficient words); write only while the block is idle.
// Throughput: one word per clock while o_pix takes results. A word accepted on
//   i_pix passes the queue, line memory read, window, multiply, row add, and
//   total add and clamp in the output register before it shows on o_pix.
// The line memories are single-port-read, single-port-write per stored row,
//   which lets the new column of the window read every stored row in the same cycle.
// Reset: position counters return to the first pixel, the queue and pipeline
//   empty, registers take their defaults. Line memories are not cleared;
//   reads are masked by position.
// Stall: when o_pix is not ready the back pipeline holds, the front keeps
//   taking words into a 4-entry queue, then drops i_pix.ready.
// Depends on c2dc_pkg, c2dc_if, c2dc_front, c2dc_queue, c2dc_back.
`timescale 1ns / 1ps
`default_nettype none

module causal_2d_convolution_clamp #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TAPS  = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [c2dc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [c2dc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    c2dc_in_if.sink                         i_pix,
    c2dc_out_if.source                      o_pix
);
    import c2dc_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int NBANK   = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int SW      = (NBANK > 1) ? $clog2(NBANK) : 1;
    localparam int ENTRY_W = 8 + CW + SW + 2 * MAX_TAPS + 1;

    t_cfg               r_cfg;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_q_valid;
    logic [ENTRY_W-1:0] w_entry_in;
    logic [ENTRY_W-1:0] w_entry_out;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_rows  <= KERNEL_ROWS_RST;
            r_cfg.kernel_cols  <= KERNEL_COLS_RST;
            r_cfg.image_width  <= IMAGE_WIDTH_RST;
            r_cfg.image_height <= IMAGE_HEIGHT_RST;
            r_cfg.coeff        <= {{((NUM_COEF-1)*COEF_W){1'b0}}, COEFF_0_RST};
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_KERNEL_ROWS:  r_cfg.kernel_rows  <= i_cfg_data[2:0];
                REG_KERNEL_COLS:  r_cfg.kernel_cols  <= i_cfg_data[2:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[11:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[15:0];
                REG_COEFF_A:      r_cfg.coeff[7:0]   <= i_cfg_data;
                REG_COEFF_B:      r_cfg.coeff[15:8]  <= i_cfg_data;
                REG_COEFF_C:      r_cfg.coeff[23:16] <= i_cfg_data;
                REG_COEFF_D:      r_cfg.coeff[24]    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    c2dc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry_in)
    );

    c2dc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_entry_out)
    );

    c2dc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_entry_out),
        .o_q_pop   (w_pop),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire

// ===== hdl/c2dc_checker.sv =====
// Port-level checks of the convolution block, bound to the top level.
// Tracks words in flight between the input and output channels.
// Depends on c2dc_pkg and causal_2d_convolution_clamp.
`timescale 1ns / 1ps
`default_nettype none

module c2dc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_pixel_out,
    input logic       i_frame_end
);
    import c2dc_pkg::*;

    localparam int PW = $clog2(MAX_PENDING + 1) + 1;

    logic          w_in_acc;
    logic          w_out_acc;
    logic [PW-1:0] r_pending;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // count words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PW'(w_in_acc) - PW'(w_out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_out) && $stable(i_frame_end))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("result word without a pending input word");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == '0 |-> i_in_ready)
        else $error("empty block refuses input");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PW'(MAX_PENDING))
        else $error("more words in flight than queue and pipeline hold");

endmodule

bind causal_2d_convolution_clamp c2dc_checker u_c2dc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_out (o_pix.pixel_out),
    .i_frame_end (o_pix.frame_end)
);

`default_nettype wire

// ===== test/c2dc_conv_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the causal 2-D convolution block: mirrors register
// writes, predicts one result word per accepted pixel and compares in order.
// Depends on c2dc_pkg and the stream interfaces in c2dc_if.
module c2dc_conv_checker #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TAPS  = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [c2dc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [c2dc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    c2dc_in_if                               i_pix,
    c2dc_out_if                              i_res,
    output int                               o_mismatches,
    output int                               o_pending
);

    import c2dc_pkg::*;

    localparam int LINE_SLOTS = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int MAX_PRINTS = 200;

    typedef struct packed {
        t_pixel pixel;
        logic   frame_end;
    } t_result;

    // mirrored configuration
    logic [2:0]  kernel_rows;
    logic [2:0]  kernel_cols;
    logic [11:0] image_width;
    logic [15:0] image_height;
    t_coef       coef [NUM_COEF];

    // mirrored datapath state
    t_pixel      line_mem [LINE_SLOTS][MAX_WIDTH];
    t_pixel      win [MAX_TAPS][MAX_TAPS];
    int unsigned col_pos;
    int unsigned row_pos;

    t_result     expected_pixels [$];
    t_result     want;
    int          mismatch_count = 0;
    int          pending_words  = 0;
    int          words_out      = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_words;

    function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the window by one pixel, sum the taps and clamp; step counters.
    function automatic t_result convolve_pixel(input t_pixel px);
        int unsigned rows;
        int unsigned cols;
        int unsigned wid;
        int unsigned hei;
        int unsigned col;
        int unsigned row;
        int          sum;
        bit          last_col;
        bit          last_row;
        t_result     r;
        rows = fit_range(kernel_rows, MAX_TAPS);
        cols = fit_range(kernel_cols, MAX_TAPS);
        wid  = fit_range(image_width, MAX_WIDTH);
        hei  = fit_range(image_height, 65535);
        col  = col_pos;
        row  = row_pos;
        sum  = 0;

        // shift columns right, load the new column from input and line store
        for (int m = 0; m < MAX_TAPS; m++) begin
            for (int n = MAX_TAPS - 1; n > 0; n--) win[m][n] = win[m][n-1];
            if (m == 0) win[m][0] = px;
            else if (row >= m) win[m][0] = line_mem[(row - m) % LINE_SLOTS][col];
            else win[m][0] = '0;
        end

        // taps above the first row or left of the first column are zero
        for (int m = 0; m < rows; m++) begin
            if (row < m) continue;
            for (int n = 0; n < cols; n++) begin
                if (col >= n) sum += int'(win[m][n]) * int'(coef[m * cols + n]);
            end
        end
        if (sum > PIX_MAX) sum = PIX_MAX;
        else if (sum < 0) sum = 0;

        if (MAX_TAPS > 1) line_mem[row % LINE_SLOTS][col] = px;

        last_col = (col + 1 >= wid);
        last_row = (row + 1 >= hei);
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end

        r.pixel     = sum[PIX_W-1:0];
        r.frame_end = last_col && last_row;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int expected);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] result word %0d: %s, got %0d, expected %0d",
                     $time, words_out, what, got, expected);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // return the model to its reset state
            kernel_rows  = KERNEL_ROWS_RST;
            kernel_cols  = KERNEL_COLS_RST;
            image_width  = IMAGE_WIDTH_RST;
            image_height = IMAGE_HEIGHT_RST;
            foreach (coef[k]) coef[k] = '0;
            coef[0] = COEFF_0_RST;
            foreach (win[m, n]) win[m][n] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_pixels.delete();
        end else begin
            // mirror register writes
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_KERNEL_ROWS:  kernel_rows  = i_cfg_data[2:0];
                    REG_KERNEL_COLS:  kernel_cols  = i_cfg_data[2:0];
                    REG_IMAGE_WIDTH:  image_width  = i_cfg_data[11:0];
                    REG_IMAGE_HEIGHT: image_height = i_cfg_data[15:0];
                    REG_COEFF_A: for (int i = 0; i < 8; i++) coef[i] = i_cfg_data[8*i +: 8];
                    REG_COEFF_B: for (int i = 0; i < 8; i++) coef[8+i] = i_cfg_data[8*i +: 8];
                    REG_COEFF_C: for (int i = 0; i < 8; i++) coef[16+i] = i_cfg_data[8*i +: 8];
                    REG_COEFF_D: coef[24] = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // compare each result word with the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("word with nothing expected", i_res.pixel_out, -1);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_res.pixel_out !== want.pixel)
                        report_mismatch("pixel_out", i_res.pixel_out, want.pixel);
                    if (i_res.frame_end !== want.frame_end)
                        report_mismatch("frame_end", i_res.frame_end, want.frame_end);
                end
                words_out++;
            end

            // predict the result of each accepted pixel word
            if (i_pix.valid && i_pix.ready)
                expected_pixels.push_back(convolve_pixel(i_pix.pixel_in));
        end
        pending_words = expected_pixels.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the convolution testbench: clock, reset, register writes, pixel
// stimulus and result back-pressure around the block and its checker.
// Depends on c2dc_pkg, c2dc_if, the block and c2dc_conv_checker.
module tb_top;

    import c2dc_pkg::*;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_TAPS     = 5;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 5_000_000;

    typedef enum int {
        COEF_ANY,
        COEF_SMALL,
        COEF_EXTREME,
        COEF_POSITIVE
    } t_coef_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     pending;

    // stimulus control shared with the receiver process
    bit                     calm = 1'b0;
    int                     hold_reqs = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;

    int                     random_items = 0;
    int                     phase = 0;
    int unsigned            cur_width;
    int                     count;
    bit                     edgy;
    logic [2:0]             new_rows;
    logic [2:0]             new_cols;
    logic [11:0]            new_width;
    logic [15:0]            new_height;
    t_coef_mode             mode;

    c2dc_in_if  pix_if ();
    c2dc_out_if res_if ();

    causal_2d_convolution_clamp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_if),
        .o_pix       (res_if)
    );

    c2dc_conv_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // end the run if the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_reqs) begin
                hold_seen++;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic write_reg(input t_reg_index idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one pixel word after a random gap; return at the next falling edge.
    task automatic push_pixel(input t_pixel px);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= px;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic t_pixel pick_pixel(input bit extremes);
        if (extremes && $urandom_range(0, 1) == 1)
            return ($urandom_range(0, 1) == 1) ? t_pixel'(PIX_MAX) : t_pixel'(0);
        return t_pixel'($urandom_range(0, 255));
    endfunction

    task automatic stream_pixels(input int n_words, input bit extremes);
        for (int i = 0; i < n_words; i++) begin
            push_pixel(pick_pixel(extremes));
            random_items++;
        end
        pix_if.valid <= 1'b0;
    endtask

    function automatic int unsigned eff_width(input logic [11:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return w;
    endfunction

    // kernel size: mostly legal, sometimes zero or above the tap limit
    function automatic logic [2:0] pick_kernel();
        case ($urandom_range(0, 9))
            0:       return 3'd0;
            1:       return 3'($urandom_range(6, 7));
            default: return 3'($urandom_range(1, 5));
        endcase
    endfunction

    // set bits above the register width now and then; they must be dropped
    function automatic logic [63:0] with_noise(input logic [63:0] value, input int width);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) return value | (junk << width);
        return value;
    endfunction

    function automatic logic [63:0] coeff_word(input t_coef_mode m);
        logic [63:0] w;
        int          v;
        w = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            case (m)
                COEF_SMALL:    v = int'($urandom_range(0, 6)) - 3;
                COEF_EXTREME:  v = ($urandom_range(0, 1) == 1) ? 127 : -128;
                COEF_POSITIVE: v = int'($urandom_range(0, 2));
                default:       v = int'(w[8*i +: 8]);
            endcase
            w[8*i +: 8] = v[7:0];
        end
        return w;
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: single unit tap, so pixels pass through
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd77);
        pix_if.valid <= 1'b0;
        wait_idle();

        // 2x2 kernel with extreme weights; the column counter starts beyond
        // the new width and must wrap on the first word
        write_reg(REG_KERNEL_ROWS, 64'd2);
        write_reg(REG_KERNEL_COLS, 64'd2);
        write_reg(REG_IMAGE_WIDTH, 64'd3);
        write_reg(REG_IMAGE_HEIGHT, 64'd2);
        write_reg(REG_COEFF_A, 64'h0000_0000_FF7F_807F);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd128);
        push_pixel(8'd1);
        pix_if.valid <= 1'b0;
        wait_idle();

        // out-of-range sizes: zero rows, oversized columns, zero width and height
        write_reg(REG_KERNEL_ROWS, 64'd0);
        write_reg(REG_KERNEL_COLS, 64'd7);
        write_reg(REG_IMAGE_WIDTH, 64'd0);
        write_reg(REG_IMAGE_HEIGHT, 64'd0);
        write_reg(REG_COEFF_A, 64'h8080_8080_8080_8002);
        push_pixel(8'd0);
        push_pixel(8'd127);
        push_pixel(8'd128);
        push_pixel(8'd255);
        pix_if.valid <= 1'b0;
        wait_idle();

        // full 5x5 kernel, width above the maximum, tallest frame
        write_reg(REG_KERNEL_ROWS, 64'd5);
        write_reg(REG_KERNEL_COLS, 64'd5);
        write_reg(REG_IMAGE_WIDTH, 64'd4095);
        write_reg(REG_IMAGE_HEIGHT, 64'd65535);
        write_reg(REG_COEFF_A, 64'h0101_0101_0101_0101);
        write_reg(REG_COEFF_B, 64'h7F7F_7F7F_7F7F_7F7F);
        write_reg(REG_COEFF_C, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEFF_D, 64'h80);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd200);
        push_pixel(8'd255);
        pix_if.valid <= 1'b0;
        wait_idle();
        cur_width = MAX_WIDTH;

        // random phases, each with its own settings
        while (random_items < RANDOM_ITEMS) begin
            new_rows = pick_kernel();
            new_cols = pick_kernel();
            case ($urandom_range(0, 9))
                0:       new_width = 12'd0;
                1:       new_width = 12'(MAX_WIDTH);
                2:       new_width = 12'($urandom_range(MAX_WIDTH + 1, 4095));
                3:       new_width = 12'($urandom_range(13, MAX_WIDTH - 1));
                default: new_width = 12'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       new_height = 16'd0;
                1:       new_height = 16'd65535;
                2:       new_height = 16'($urandom_range(7, 65534));
                default: new_height = 16'($urandom_range(1, 6));
            endcase
            mode = t_coef_mode'($urandom_range(0, 3));

            // rewind to the first pixel of a frame before the rows grow,
            // so no line store entry is read before it is written
            if (eff_width(new_width) > cur_width) begin
                write_reg(REG_IMAGE_WIDTH, 64'd1);
                write_reg(REG_IMAGE_HEIGHT, 64'd1);
                push_pixel(pick_pixel(1'b0));
                pix_if.valid <= 1'b0;
                wait_idle();
            end

            write_reg(REG_KERNEL_ROWS, with_noise(64'(new_rows), 3));
            write_reg(REG_KERNEL_COLS, with_noise(64'(new_cols), 3));
            write_reg(REG_IMAGE_WIDTH, with_noise(64'(new_width), 12));
            write_reg(REG_IMAGE_HEIGHT, with_noise(64'(new_height), 16));
            write_reg(REG_COEFF_A, coeff_word(mode));
            write_reg(REG_COEFF_B, coeff_word(mode));
            write_reg(REG_COEFF_C, coeff_word(mode));
            write_reg(REG_COEFF_D, with_noise(coeff_word(mode) & 64'hFF, 8));
            cur_width = eff_width(new_width);

            count = (cur_width > 12) ? 30 : int'($urandom_range(40, 120));
            edgy  = ($urandom_range(0, 3) == 0);
            // one phase with no idling, one where the result side holds off
            // long enough to fill the block and stall its input
            if (phase == 2) begin
                calm  = 1'b1;
                count = 120;
            end
            if (phase == 4) begin
                hold_reqs++;
                count = 120;
            end
            stream_pixels(count, edgy);
            wait_idle();
            calm = 1'b0;
            phase++;
        end

        // drain and give the verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
